// ----- rtl/chtc_pkg.sv -----
// ----------------------------------------------------------------------------
// chtc_pkg
// Shared types, register indexes, widths and the CORDIC angle table of the
// compass heading turn controller.
// ----------------------------------------------------------------------------
package chtc_pkg;

	localparam int MAG_W   = 12;
	localparam int HEAD_W  = 13;
	localparam int SPD_W   = 10;
	localparam int IDX_W   = 3;
	localparam int CFG_W   = 13;
	localparam int NUM_W   = 26;
	localparam int DEN_W   = 12;
	localparam int XY_W    = 30;
	localparam int Z_W     = 22;
	localparam int ATAN_N  = 24;

	localparam int DEF_SAMPLES = 10;
	localparam int DEF_STEPS   = 16;

	localparam logic [IDX_W-1:0] REG_MIN_X    = 3'd0;
	localparam logic [IDX_W-1:0] REG_MAX_X    = 3'd1;
	localparam logic [IDX_W-1:0] REG_MIN_Y    = 3'd2;
	localparam logic [IDX_W-1:0] REG_MAX_Y    = 3'd3;
	localparam logic [IDX_W-1:0] REG_TARGET   = 3'd4;
	localparam logic [IDX_W-1:0] REG_DEADBAND = 3'd5;
	localparam logic [IDX_W-1:0] REG_STYLE    = 3'd6;

	localparam logic signed [Z_W-1:0] QUARTER_Z = 22'sd368640;
	localparam logic signed [Z_W-1:0] FULL_Z    = 22'sd1474560;

	typedef enum logic [3:0] {
		S_IDLE, S_AX, S_AY, S_SX, S_SY, S_PRE, S_ROT, S_HEAD, S_SPD, S_LOAD
	} state_t;

	typedef enum logic [2:0] {
		OP_AX, OP_AY, OP_SX, OP_SY, OP_SPD
	} div_op_t;

	typedef struct packed {
		logic    accept;
		logic    div_start;
		div_op_t div_op;
		logic    recip_load;
		logic    cordic_init;
		logic    cordic_step;
		logic    finish;
		logic    load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic last_sample;
		logic out_full;
		logic div_busy;
		logic div_done;
		logic cordic_last;
	} dp_stat_t;

	function automatic logic signed [Z_W-1:0] atan_z(input logic [4:0] i);
		logic signed [Z_W-1:0] r;
		case (i)
			5'd0:  r = 22'sd184320;
			5'd1:  r = 22'sd108810;
			5'd2:  r = 22'sd57492;
			5'd3:  r = 22'sd29184;
			5'd4:  r = 22'sd14649;
			5'd5:  r = 22'sd7331;
			5'd6:  r = 22'sd3667;
			5'd7:  r = 22'sd1833;
			5'd8:  r = 22'sd917;
			5'd9:  r = 22'sd458;
			5'd10: r = 22'sd229;
			5'd11: r = 22'sd115;
			5'd12: r = 22'sd57;
			5'd13: r = 22'sd29;
			5'd14: r = 22'sd14;
			5'd15: r = 22'sd7;
			5'd16: r = 22'sd4;
			5'd17: r = 22'sd2;
			5'd18: r = 22'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/chtc_div.sv -----
// ----------------------------------------------------------------------------
// chtc_div
// Radix-2 restoring divider, one quotient bit per cycle, signed result
// truncated toward zero.
// ----------------------------------------------------------------------------
module chtc_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [chtc_pkg::NUM_W-1:0]        num,
	input  logic [chtc_pkg::DEN_W-1:0]        den,
	input  logic                              neg,
	output logic                              busy,
	output logic                              done,
	output logic signed [chtc_pkg::NUM_W:0]   quot
);
	import chtc_pkg::*;

	localparam int CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic             neg_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			neg_q <= neg;
		end else if (busy_q) begin
			// shift in one quotient bit
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});

endmodule

// ----- rtl/chtc_dp.sv -----
// ----------------------------------------------------------------------------
// chtc_dp
// Datapath: configuration registers, sample sums, divider operand select,
// CORDIC vectoring registers, heading error and output word register.
// ----------------------------------------------------------------------------
module chtc_dp #(
	parameter int SAMPLES_PER_HEADING = chtc_pkg::DEF_SAMPLES,
	parameter int CORDIC_STEPS        = chtc_pkg::DEF_STEPS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  chtc_pkg::ctrl_cmd_t                 cmd,
	output chtc_pkg::dp_stat_t                  stat,
	input  logic                                cfg_we,
	input  logic [chtc_pkg::IDX_W-1:0]          cfg_index,
	input  logic [chtc_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic signed [chtc_pkg::MAG_W-1:0]   mag_x,
	input  logic signed [chtc_pkg::MAG_W-1:0]   mag_y,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [chtc_pkg::HEAD_W-1:0]         heading_now,
	output logic signed [chtc_pkg::HEAD_W-1:0]  heading_error,
	output logic signed [chtc_pkg::SPD_W-1:0]   left_speed,
	output logic signed [chtc_pkg::SPD_W-1:0]   right_speed,
	output logic                                on_target
);
	import chtc_pkg::*;

	localparam int N      = SAMPLES_PER_HEADING;
	localparam int STEPS  = (CORDIC_STEPS > ATAN_N) ? ATAN_N : CORDIC_STEPS;
	localparam int CNT_W  = $clog2(N + 1);
	localparam int SUM_W  = MAG_W + $clog2(N + 1) + 1;
	localparam int STEP_W = $clog2(STEPS);
	// exact reciprocal of N over the sum magnitude range
	localparam int AVG_SH  = SUM_W - 1 + $clog2(N);
	localparam int AVG_PW  = SUM_W + AVG_SH;
	localparam int AVG_RCP = (2 ** AVG_SH + N - 1) / N;
	// 200/2880 reduces to 5/72; exact reciprocal of 72 for numerators below 2^14
	localparam int SPD_SH  = 21;
	localparam int SPD_RCP = 29128;

	// configuration
	logic signed [MAG_W-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic [HEAD_W-1:0]       target_q;
	logic [7:0]              deadband_q;
	logic                    style_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q    <= -12'sd2047;
			max_x_q    <= 12'sd2047;
			min_y_q    <= -12'sd2047;
			max_y_q    <= 12'sd2047;
			target_q   <= '0;
			deadband_q <= 8'd3;
			style_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_X:    min_x_q    <= cfg_wdata[MAG_W-1:0];
				REG_MAX_X:    max_x_q    <= cfg_wdata[MAG_W-1:0];
				REG_MIN_Y:    min_y_q    <= cfg_wdata[MAG_W-1:0];
				REG_MAX_Y:    max_y_q    <= cfg_wdata[MAG_W-1:0];
				REG_TARGET:   target_q   <= cfg_wdata[HEAD_W-1:0];
				REG_DEADBAND: deadband_q <= cfg_wdata[7:0];
				REG_STYLE:    style_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// sample sums
	logic signed [SUM_W-1:0] sum_x_q, sum_y_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    last;

	assign last = cnt_q == CNT_W'(N - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			cnt_q   <= '0;
		end else if (cmd.accept) begin
			sum_x_q <= sum_x_q + SUM_W'(mag_x);
			sum_y_q <= sum_y_q + SUM_W'(mag_y);
			cnt_q   <= last ? '0 : cnt_q + 1'b1;
		end else if (cmd.load_out) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
		end
	end

	// divider operands
	logic signed [MAG_W-1:0]  avg_x_q, avg_y_q;
	logic signed [XY_W-1:0]   sx_q, sy_q;
	logic signed [HEAD_W-1:0] err_q;
	logic signed [SPD_W-1:0]  spd_q;
	logic [HEAD_W-1:0]        head_q;
	logic                     on_q;

	logic [NUM_W-1:0]         d_num;
	logic [DEN_W-1:0]         d_den;
	logic                     d_neg;
	logic signed [NUM_W:0]    d_quot;
	logic                     d_busy, d_done;

	logic signed [SUM_W-1:0]  sum_sel;
	logic signed [MAG_W-1:0]  avg_sel, lo_sel, hi_sel;
	logic signed [MAG_W:0]    diff, span_raw;
	logic [DEN_W-1:0]         span;
	logic signed [MAG_W+2:0]  t_val;
	logic [MAG_W+2:0]         t_mag;
	logic [HEAD_W-1:0]        err_mag;
	logic [SUM_W-2:0]         sum_mag;
	logic [AVG_PW-1:0]        avg_prod;
	logic [MAG_W:0]           avg_mag;
	logic signed [MAG_W-1:0]  avg_val;
	logic [14:0]              spd_num;
	logic [29:0]              spd_prod;
	logic [SPD_W-2:0]         spd_mag;
	logic signed [SPD_W-1:0]  spd_val;

	always_comb begin
		sum_sel  = (cmd.div_op == OP_AY) ? sum_y_q : sum_x_q;
		avg_sel  = (cmd.div_op == OP_SY) ? avg_y_q : avg_x_q;
		lo_sel   = (cmd.div_op == OP_SY) ? min_y_q : min_x_q;
		hi_sel   = (cmd.div_op == OP_SY) ? max_y_q : max_x_q;
		diff     = (MAG_W+1)'(avg_sel) - (MAG_W+1)'(lo_sel);
		span_raw = (MAG_W+1)'(hi_sel) - (MAG_W+1)'(lo_sel);
		// clamp a span that is not positive to one
		span     = (span_raw <= 0) ? DEN_W'(1) : span_raw[DEN_W-1:0];
		t_val    = ((MAG_W+3)'(diff) <<< 1) - $signed((MAG_W+3)'(span));
		t_mag    = t_val[MAG_W+2] ? (MAG_W+3)'(-t_val) : (MAG_W+3)'(t_val);
		err_mag  = err_q[HEAD_W-1] ? HEAD_W'(-err_q) : HEAD_W'(err_q);
		// average: divide the magnitude, then restore the sign
		sum_mag  = sum_sel[SUM_W-1] ? (SUM_W-1)'(-sum_sel) : (SUM_W-1)'(sum_sel);
		avg_prod = AVG_PW'(sum_mag) * AVG_PW'(AVG_RCP);
		avg_mag  = avg_prod[AVG_SH +: MAG_W+1];
		avg_val  = sum_sel[SUM_W-1] ? MAG_W'(-avg_mag) : MAG_W'(avg_mag);
		spd_num  = 15'(err_mag) * 15'd5;
		spd_prod = 30'(spd_num) * 30'(SPD_RCP);
		spd_mag  = spd_prod[SPD_SH +: SPD_W-1];
		spd_val  = err_q[HEAD_W-1] ? -$signed({1'b0, spd_mag}) : $signed({1'b0, spd_mag});
		case (cmd.div_op)
			OP_SX, OP_SY: begin
				d_num = {t_mag[13:0], 12'b0};
				d_den = span;
				d_neg = t_val[MAG_W+2];
			end
			default: begin
				d_num = '0;
				d_den = DEN_W'(1);
				d_neg = 1'b0;
			end
		endcase
	end

	chtc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (d_num),
		.den    (d_den),
		.neg    (d_neg),
		.busy   (d_busy),
		.done   (d_done),
		.quot   (d_quot)
	);

	always_ff @(posedge clk) begin
		if (cmd.recip_load) begin
			case (cmd.div_op)
				OP_AX:   avg_x_q <= avg_val;
				OP_AY:   avg_y_q <= avg_val;
				OP_SPD:  spd_q   <= spd_val;
				default: ;
			endcase
		end else if (d_done) begin
			case (cmd.div_op)
				OP_SX:   sx_q    <= XY_W'(d_quot);
				OP_SY:   sy_q    <= XY_W'(d_quot);
				default: ;
			endcase
		end
	end

	// CORDIC vectoring
	logic signed [XY_W-1:0] x_q, y_q, x_sh, y_sh;
	logic signed [Z_W-1:0]  z_q, a_z;
	logic [STEP_W-1:0]      step_q;
	logic                   zero_q;

	always_comb begin
		x_sh = x_q >>> step_q;
		y_sh = y_q >>> step_q;
		a_z  = atan_z(5'(step_q));
	end

	always_ff @(posedge clk) begin
		if (cmd.cordic_init) begin
			zero_q <= (sx_q == 0) && (sy_q == 0);
			step_q <= '0;
			// fold the left half plane onto the right
			if (sx_q < 0 && sy_q >= 0) begin
				x_q <= sy_q;
				y_q <= -sx_q;
				z_q <= QUARTER_Z;
			end else if (sx_q < 0) begin
				x_q <= -sy_q;
				y_q <= sx_q;
				z_q <= -QUARTER_Z;
			end else begin
				x_q <= sx_q;
				y_q <= sy_q;
				z_q <= '0;
			end
		end else if (cmd.cordic_step) begin
			step_q <= step_q + 1'b1;
			if (y_q >= 0) begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + a_z;
			end else begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - a_z;
			end
		end
	end

	// heading and wrapped error
	logic signed [Z_W-1:0]  z_pos, z_rnd;
	logic [HEAD_W:0]        h_raw;
	logic [HEAD_W-1:0]      h_val, tgt;
	logic signed [HEAD_W:0] e_raw, e_wrap;

	always_comb begin
		z_pos  = (z_q < 0) ? z_q + FULL_Z : z_q;
		z_rnd  = z_pos + 22'sd128;
		h_raw  = z_rnd[Z_W-1:8];
		h_val  = (h_raw >= 14'd5760) ? HEAD_W'(h_raw - 14'd5760) : h_raw[HEAD_W-1:0];
		if (zero_q)
			h_val = '0;
		tgt    = (target_q >= 13'd5760) ? target_q - 13'd5760 : target_q;
		e_raw  = $signed({1'b0, tgt}) - $signed({1'b0, h_val});
		if (e_raw > 14'sd2880)
			e_wrap = e_raw - 14'sd5760;
		else if (e_raw < -14'sd2880)
			e_wrap = e_raw + 14'sd5760;
		else
			e_wrap = e_raw;
	end

	logic [HEAD_W-1:0] e_mag;
	assign e_mag = e_wrap[HEAD_W] ? HEAD_W'(-e_wrap) : HEAD_W'(e_wrap);

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			head_q <= h_val;
			err_q  <= e_wrap[HEAD_W-1:0];
			on_q   <= e_mag < {1'b0, deadband_q, 4'b0};
		end
	end

	// output word
	logic              out_full_q;
	logic signed [SPD_W-1:0] l_val, r_val, s_bias;

	always_comb begin
		s_bias = (spd_q < 0) ? spd_q - 10'sd100 : spd_q + 10'sd100;
		if (on_q) begin
			l_val = '0;
			r_val = '0;
		end else if (style_q) begin
			l_val = (spd_q < 0) ? 10'sd80 : 10'sd150;
			r_val = (spd_q < 0) ? 10'sd150 : 10'sd80;
		end else begin
			l_val = s_bias;
			r_val = -s_bias;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_full_q <= 1'b0;
		else if (cmd.load_out)
			out_full_q <= 1'b1;
		else if (out_ready)
			out_full_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			heading_now   <= head_q;
			heading_error <= err_q;
			left_speed    <= l_val;
			right_speed   <= r_val;
			on_target     <= on_q;
		end
	end

	assign out_valid        = out_full_q;
	assign stat.last_sample = last;
	assign stat.out_full    = out_full_q;
	assign stat.div_busy    = d_busy;
	assign stat.div_done    = d_done;
	assign stat.cordic_last = step_q == STEP_W'(STEPS - 1);

endmodule

// ----- rtl/chtc_ctrl.sv -----
// ----------------------------------------------------------------------------
// chtc_ctrl
// Sequencer: accepts samples, then walks the divider, CORDIC and output
// load steps of one heading.
// ----------------------------------------------------------------------------
module chtc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  chtc_pkg::dp_stat_t   stat,
	output chtc_pkg::ctrl_cmd_t  cmd
);
	import chtc_pkg::*;

	state_t state_q, state_d;
	logic   is_div;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid && in_ready && stat.last_sample) state_d = S_AX;
			S_AX:   state_d = S_AY;
			S_AY:   state_d = S_SX;
			S_SX:   if (stat.div_done) state_d = S_SY;
			S_SY:   if (stat.div_done) state_d = S_PRE;
			S_PRE:  state_d = S_ROT;
			S_ROT:  if (stat.cordic_last) state_d = S_HEAD;
			S_HEAD: state_d = S_SPD;
			S_SPD:  state_d = S_LOAD;
			S_LOAD: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		// hold the last sample back while the previous word is still waiting
		in_ready = (state_q == S_IDLE) && !(stat.last_sample && stat.out_full);
		is_div   = (state_q == S_SX) || (state_q == S_SY);
		cmd.accept      = in_valid && in_ready;
		cmd.div_start   = is_div && !stat.div_busy && !stat.div_done;
		cmd.recip_load  = (state_q == S_AX) || (state_q == S_AY) || (state_q == S_SPD);
		cmd.cordic_init = state_q == S_PRE;
		cmd.cordic_step = state_q == S_ROT;
		cmd.finish      = state_q == S_HEAD;
		cmd.load_out    = state_q == S_LOAD;
		case (state_q)
			S_AY:    cmd.div_op = OP_AY;
			S_SX:    cmd.div_op = OP_SX;
			S_SY:    cmd.div_op = OP_SY;
			S_SPD:   cmd.div_op = OP_SPD;
			default: cmd.div_op = OP_AX;
		endcase
	end

endmodule

// ----- rtl/compass_heading_turn_controller.sv -----
// ----------------------------------------------------------------------------
// compass_heading_turn_controller
// Averages magnetometer samples, forms a heading by CORDIC and drives the
// motor commands toward the target heading.
// ----------------------------------------------------------------------------
// Every SAMPLES_PER_HEADING-th accepted sample starts a heading computation:
// averaging of both axes by reciprocal multiply, two span divisions on a
// radix-2 divider, CORDIC vectoring, then the heading, speed and output load
// steps, during which no sample is taken. The result word sits in an output
// register; samples keep being accepted while it waits, except the one that
// would start the next heading.
module compass_heading_turn_controller #(
	parameter int SAMPLES_PER_HEADING = chtc_pkg::DEF_SAMPLES,
	parameter int CORDIC_STEPS        = chtc_pkg::DEF_STEPS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [chtc_pkg::IDX_W-1:0]          cfg_index,
	input  logic [chtc_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [chtc_pkg::MAG_W-1:0]   mag_x,
	input  logic signed [chtc_pkg::MAG_W-1:0]   mag_y,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [chtc_pkg::HEAD_W-1:0]         heading_now,
	output logic signed [chtc_pkg::HEAD_W-1:0]  heading_error,
	output logic signed [chtc_pkg::SPD_W-1:0]   left_speed,
	output logic signed [chtc_pkg::SPD_W-1:0]   right_speed,
	output logic                                on_target
);
	import chtc_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	chtc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	chtc_dp #(
		.SAMPLES_PER_HEADING (SAMPLES_PER_HEADING),
		.CORDIC_STEPS        (CORDIC_STEPS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.mag_x         (mag_x),
		.mag_y         (mag_y),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.heading_now   (heading_now),
		.heading_error (heading_error),
		.left_speed    (left_speed),
		.right_speed   (right_speed),
		.on_target     (on_target)
	);

endmodule
